// ===== rtl/core/mcp_pkg.sv =====
// Shared constants and types of the Mobius curve pixel plotter.
`timescale 1ns / 1ps
package mcp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int SPAN_W  = 31;
  localparam int COORD_W = 32;
  localparam int MAT_W   = COORD_W + 1;
  localparam int PD_W    = DIM_W + SPAN_W;
  localparam int PQ_W    = SPAN_W - 1;
  localparam int NUM_W   = 2 * COORD_W;
  localparam int DEN_W   = NUM_W - 1;
  localparam int T_W     = COORD_W + 3;
  localparam int X_W     = DIM_W + COORD_W;

  localparam int IN_DATA_W  = ((IDX_W + 4 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * IDX_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_REAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_IMAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y      = 3'd5;

  localparam logic [DIM_W-1:0]          DIM_RST    = DIM_W'(512);
  localparam logic signed [COORD_W-1:0] CENTRE_RST = COORD_W'(32768);
  localparam logic [SPAN_W-1:0]         SPAN_RST   = SPAN_W'(65536);

  typedef struct packed {
    logic             inv;
    logic             miss;
    logic [IDX_W-1:0] idx;
  } mcp_tag_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] a;
    logic signed [MAT_W-1:0] b;
    logic signed [MAT_W-1:0] c;
    logic signed [MAT_W-1:0] d;
  } mcp_mat_t;

endpackage

// ===== rtl/core/mcp_point.sv =====
// Sample point: span product, pipelined division by twice the size, floor and saturation.
`timescale 1ns / 1ps
module mcp_point
  import mcp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  mcp_tag_t                  tag_i,
  input  mcp_mat_t                  mat_i,
  input  logic                      vneg_i,
  input  logic [DIM_W-1:0]          vmag_i,
  input  logic [SPAN_W-1:0]         span_i,
  input  logic [DIM_W:0]            n2_i,
  input  logic signed [COORD_W-1:0] centre_i,
  output logic                      valid_o,
  output mcp_tag_t                  tag_o,
  output mcp_mat_t                  mat_o,
  output logic signed [COORD_W-1:0] point_o
);

  localparam int Steps = PQ_W;

  logic [Steps+1:0] vld_q;
  mcp_tag_t         tag_q [Steps+1];
  mcp_mat_t         mat_q [Steps+1];
  logic             neg_q [Steps+1];
  logic [DIM_W:0]   n2_q  [Steps+1];
  logic [PD_W-1:0]  rem_q [Steps+1];
  logic [PQ_W-1:0]  quo_q [Steps+1];

  mcp_tag_t                  fin_tag_q;
  mcp_mat_t                  fin_mat_q;
  logic signed [COORD_W-1:0] point_q;

  logic [PQ_W:0]             qadj;
  logic signed [COORD_W:0]   qs;
  logic signed [COORD_W:0]   sum;
  logic signed [COORD_W-1:0] point_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      mat_q[0] <= mat_i;
      neg_q[0] <= vneg_i;
      n2_q[0]  <= n2_i;
      rem_q[0] <= PD_W'(span_i) * PD_W'(vmag_i);
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= Steps; j++) begin : g_step
    logic [PD_W-1:0] dsh;
    logic            ge;
    assign dsh = PD_W'(n2_q[j-1]) << (Steps - j);
    assign ge  = rem_q[j-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j] <= tag_q[j-1];
        mat_q[j] <= mat_q[j-1];
        neg_q[j] <= neg_q[j-1];
        n2_q[j]  <= n2_q[j-1];
        rem_q[j] <= ge ? rem_q[j-1] - dsh : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (PQ_W'(ge) << (Steps - j));
      end
    end
  end

  always_comb begin
    qadj = {1'b0, quo_q[Steps]} + (PQ_W+1)'(neg_q[Steps] && (rem_q[Steps] != '0));
    qs   = neg_q[Steps] ? -$signed((COORD_W+1)'(qadj)) : $signed((COORD_W+1)'(qadj));
    sum  = $signed({centre_i[COORD_W-1], centre_i}) + qs;
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      point_d = sum[COORD_W] ? $signed({1'b1, {(COORD_W-1){1'b0}}})
                             : $signed({1'b0, {(COORD_W-1){1'b1}}});
    end else begin
      point_d = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_tag_q <= tag_q[Steps];
      fin_mat_q <= mat_q[Steps];
      point_q   <= point_d;
    end
  end

  assign valid_o = vld_q[Steps+1];
  assign tag_o   = fin_tag_q;
  assign mat_o   = fin_mat_q;
  assign point_o = point_q;

endmodule

// ===== rtl/core/mcp_frac.sv =====
// Map evaluation: numerator and denominator products, pipelined remainder and fraction bits.
`timescale 1ns / 1ps
module mcp_frac
  import mcp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  mcp_tag_t                  tag_i,
  input  mcp_mat_t                  mat_i,
  input  logic signed [COORD_W-1:0] point_i,
  output logic                      valid_o,
  output mcp_tag_t                  tag_o,
  output logic [FRAC_BITS-1:0]      frac_o
);

  localparam int Lat = DEN_W + FRAC_BITS + 5;

  logic [Lat-1:0] vld_q;

  mcp_tag_t                mul_tag_q;
  logic signed [NUM_W-1:0] ap_q, bs_q, cp_q, ds_q;

  mcp_tag_t                sum_tag_q;
  logic signed [NUM_W-1:0] num_q, den_q;

  mcp_tag_t                nrm_tag_d, nrm_tag_q;
  logic                    dneg;
  logic signed [NUM_W-1:0] nn_d, dd_d, nn_q;
  logic [DEN_W-1:0]        nd_q;
  logic signed [NUM_W-1:0] nabs;

  mcp_tag_t         rtag_q [DEN_W+1];
  logic             rneg_q [DEN_W+1];
  logic [DEN_W-1:0] rden_q [DEN_W+1];
  logic [DEN_W-1:0] rrem_q [DEN_W+1];

  logic [DEN_W-1:0] cor;

  mcp_tag_t             ftag_q [FRAC_BITS+1];
  logic [DEN_W-1:0]     fden_q [FRAC_BITS+1];
  logic [DEN_W-1:0]     frem_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fval_q [FRAC_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_comb begin
    dneg           = den_q[NUM_W-1];
    nn_d           = dneg ? -num_q : num_q;
    dd_d           = dneg ? -den_q : den_q;
    nrm_tag_d      = sum_tag_q;
    nrm_tag_d.miss = sum_tag_q.miss | (den_q == '0);
    nabs           = nn_q[NUM_W-1] ? -nn_q : nn_q;
    cor            = (rneg_q[DEN_W] && (rrem_q[DEN_W] != '0))
                   ? rden_q[DEN_W] - rrem_q[DEN_W] : rrem_q[DEN_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_tag_q <= tag_i;
      ap_q      <= NUM_W'(mat_i.a) * NUM_W'(point_i);
      cp_q      <= NUM_W'(mat_i.c) * NUM_W'(point_i);
      bs_q      <= NUM_W'(mat_i.b) <<< FRAC_BITS;
      ds_q      <= NUM_W'(mat_i.d) <<< FRAC_BITS;

      sum_tag_q <= mul_tag_q;
      num_q     <= ap_q + bs_q;
      den_q     <= cp_q + ds_q;

      nrm_tag_q <= nrm_tag_d;
      nn_q      <= nn_d;
      nd_q      <= dd_d[DEN_W-1:0];

      rtag_q[0] <= nrm_tag_q;
      rneg_q[0] <= nn_q[NUM_W-1];
      rden_q[0] <= nd_q;
      rrem_q[0] <= nabs[DEN_W-1:0];

      ftag_q[0] <= rtag_q[DEN_W];
      fden_q[0] <= rden_q[DEN_W];
      frem_q[0] <= cor;
      fval_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DEN_W; j++) begin : g_rem
    localparam int K = DEN_W - j;
    logic             fits;
    logic [DEN_W-1:0] dsh;
    logic             ge;
    if (K == 0) begin : g_last
      assign fits = 1'b1;
    end else begin : g_high
      assign fits = (rden_q[j-1] >> (DEN_W - K)) == '0;
    end
    assign dsh = rden_q[j-1] << K;
    assign ge  = fits && (rrem_q[j-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rtag_q[j] <= rtag_q[j-1];
        rneg_q[j] <= rneg_q[j-1];
        rden_q[j] <= rden_q[j-1];
        rrem_q[j] <= ge ? rrem_q[j-1] - dsh : rrem_q[j-1];
      end
    end
  end

  for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_bit
    logic [DEN_W:0] r2;
    logic [DEN_W:0] rn;
    logic           ge;
    assign r2 = {frem_q[j-1], 1'b0};
    assign ge = r2 >= {1'b0, fden_q[j-1]};
    assign rn = r2 - {1'b0, fden_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ftag_q[j] <= ftag_q[j-1];
        fden_q[j] <= fden_q[j-1];
        frem_q[j] <= ge ? rn[DEN_W-1:0] : r2[DEN_W-1:0];
        fval_q[j] <= {fval_q[j-1][FRAC_BITS-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign tag_o   = ftag_q[FRAC_BITS];
  assign frac_o  = fval_q[FRAC_BITS];

endmodule

// ===== rtl/core/mcp_scale.sv =====
// Pixel scaling: range check, size product, pipelined division by twice the span, mirroring.
`timescale 1ns / 1ps
module mcp_scale
  import mcp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  mcp_tag_t                  tag_i,
  input  logic [FRAC_BITS-1:0]      frac_i,
  input  logic [DIM_W-1:0]          columns_i,
  input  logic [DIM_W-1:0]          rows_i,
  input  logic [SPAN_W-1:0]         span_i,
  input  logic signed [COORD_W-1:0] centre_i,
  output logic                      valid_o,
  output logic [IDX_W-1:0]          col_o,
  output logic [IDX_W-1:0]          row_o,
  output logic                      hit_o
);

  localparam int Lat = IDX_W + 3;

  logic [Lat-1:0] vld_q;

  mcp_tag_t              tag0_q;
  logic signed [T_W-1:0] t_q;
  logic [DIM_W-1:0]      m0_q;

  logic [COORD_W-1:0] dd;
  mcp_tag_t           tag1_d;

  mcp_tag_t         tag_q [IDX_W+1];
  logic [DIM_W-1:0] m_q   [IDX_W+1];
  logic [X_W-1:0]   x_q   [IDX_W+1];
  logic [IDX_W-1:0] q_q   [IDX_W+1];

  logic [DIM_W-1:0] jj;
  logic             hit_d;
  logic [IDX_W-1:0] col_d, row_d;
  logic [IDX_W-1:0] col_q, row_q;
  logic             hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  assign dd = {span_i, 1'b0};

  always_comb begin
    tag1_d      = tag0_q;
    tag1_d.miss = tag0_q.miss | t_q[T_W-1] | (t_q[T_W-2:0] >= (T_W-1)'(dd));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag0_q <= tag_i;
      t_q    <= T_W'(span_i) + (T_W'(frac_i) << 1) - (T_W'(centre_i) <<< 1);
      m0_q   <= tag_i.inv ? columns_i : rows_i;

      tag_q[0] <= tag1_d;
      m_q[0]   <= m0_q;
      x_q[0]   <= X_W'(m0_q) * X_W'(t_q[SPAN_W:0]);
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= IDX_W; j++) begin : g_step
    logic [X_W-1:0] dsh;
    logic           ge;
    assign dsh = X_W'(dd) << (IDX_W - j);
    assign ge  = x_q[j-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j] <= tag_q[j-1];
        m_q[j]   <= m_q[j-1];
        x_q[j]   <= ge ? x_q[j-1] - dsh : x_q[j-1];
        q_q[j]   <= q_q[j-1] | (IDX_W'(ge) << (IDX_W - j));
      end
    end
  end

  always_comb begin
    jj    = m_q[IDX_W] - DIM_W'(1) - DIM_W'(q_q[IDX_W]);
    hit_d = !tag_q[IDX_W].miss;
    col_d = '0;
    row_d = '0;
    if (hit_d) begin
      col_d = tag_q[IDX_W].inv ? jj[IDX_W-1:0] : tag_q[IDX_W].idx;
      row_d = tag_q[IDX_W].inv ? tag_q[IDX_W].idx : jj[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_d;
      row_q <= row_d;
      hit_q <= hit_d;
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign hit_o   = hit_q;

endmodule

// ===== rtl/core/mobius_curve_pixel_plotter_top.sv =====
// Top level of the Mobius curve pixel plotter: configuration, input stage and pipeline.
`timescale 1ns / 1ps
// Usage:
//   Slave stream: one sample per transfer, the pass select in tuser, the sample
//   index and the four matrix entries in tdata. Master stream: one result per
//   sample, the pixel column and row in tdata, the hit flag in tuser.
//   Configuration: write enable, register index and data; a register takes the
//   data at the clock edge while the enable is high. Write only while idle.
// Pipeline stages from input transfer to result valid: input stage 1,
//   sample point 32 (product, 30 quotient steps, floor), map 84 (products,
//   sums, sign fix, 63 remainder steps, 16 fraction steps), scaling 15.
// Throughput: one sample per cycle; all stages advance together while the
//   output register is empty or being taken.
// Reset: clears all valid bits and loads the default view: 512 x 512 image,
//   centre 0.5 + 0.5i, spans 1.0.
// Stall: while a result waits and the receiver holds tready low, the whole
//   pipeline holds and tready on the slave side drops; nothing is lost.
module mobius_curve_pixel_plotter_top
  import mcp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [11:0] sample_index, [43:12] mat_a, [75:44] mat_b, [107:76] mat_c,
  // [139:108] mat_d, [143:140] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [11:0] pixel_col, [23:12] pixel_row
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] hit
  output logic [0:0]            m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AOff = IDX_W;
  localparam int BOff = AOff + COORD_W;
  localparam int COff = BOff + COORD_W;
  localparam int DOff = COff + COORD_W;

  logic [DIM_W-1:0]          columns_q, rows_q;
  logic signed [COORD_W-1:0] centre_real_q, centre_imag_q;
  logic [SPAN_W-1:0]         span_x_q, span_y_q;

  logic en;

  logic                      inv;
  logic [IDX_W-1:0]          idx;
  logic signed [MAT_W-1:0]   ra, rb, rc, rd;
  logic [DIM_W-1:0]          n;
  logic [DIM_W:0]            v;
  logic                      bad;
  mcp_tag_t                  in_tag_d;
  mcp_mat_t                  in_mat_d;

  logic                      in_vld_q;
  mcp_tag_t                  in_tag_q;
  mcp_mat_t                  in_mat_q;
  logic                      in_vneg_q;
  logic [DIM_W-1:0]          in_vmag_q;
  logic [SPAN_W-1:0]         in_span_q;
  logic [DIM_W:0]            in_n2_q;

  logic                      pt_vld;
  mcp_tag_t                  pt_tag;
  mcp_mat_t                  pt_mat;
  logic signed [COORD_W-1:0] pt_point;

  logic                      fr_vld;
  mcp_tag_t                  fr_tag;
  logic [FRAC_BITS-1:0]      fr_frac;

  logic                      out_vld;
  logic [IDX_W-1:0]          out_col, out_row;
  logic                      out_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= DIM_RST;
      rows_q        <= DIM_RST;
      centre_real_q <= CENTRE_RST;
      centre_imag_q <= CENTRE_RST;
      span_x_q      <= SPAN_RST;
      span_y_q      <= SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMNS:     columns_q     <= cfg_data_i[DIM_W-1:0];
        CFG_ROWS:        rows_q        <= cfg_data_i[DIM_W-1:0];
        CFG_CENTRE_REAL: centre_real_q <= cfg_data_i;
        CFG_CENTRE_IMAG: centre_imag_q <= cfg_data_i;
        CFG_SPAN_X:      span_x_q      <= cfg_data_i[SPAN_W-1:0];
        CFG_SPAN_Y:      span_y_q      <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    inv = s_axis_tuser[0];
    idx = s_axis_tdata[IDX_W-1:0];
    ra  = MAT_W'($signed(s_axis_tdata[AOff +: COORD_W]));
    rb  = MAT_W'($signed(s_axis_tdata[BOff +: COORD_W]));
    rc  = MAT_W'($signed(s_axis_tdata[COff +: COORD_W]));
    rd  = MAT_W'($signed(s_axis_tdata[DOff +: COORD_W]));
    n   = inv ? rows_q : columns_q;
    v   = {1'b0, idx, 1'b1} - {1'b0, n};
    bad = (columns_q == '0) || (rows_q == '0)
       || (columns_q > DIM_W'(MAX_DIM)) || (rows_q > DIM_W'(MAX_DIM))
       || (span_x_q == '0) || (span_y_q == '0)
       || ({1'b0, idx} >= n);
    in_tag_d.inv  = inv;
    in_tag_d.miss = bad;
    in_tag_d.idx  = idx;
    in_mat_d.a    = inv ? rd : ra;
    in_mat_d.b    = inv ? -rb : rb;
    in_mat_d.c    = inv ? -rc : rc;
    in_mat_d.d    = inv ? ra : rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_tag_q  <= in_tag_d;
      in_mat_q  <= in_mat_d;
      in_vneg_q <= v[DIM_W];
      in_vmag_q <= v[DIM_W] ? DIM_W'(-v) : v[DIM_W-1:0];
      in_span_q <= inv ? span_y_q : span_x_q;
      in_n2_q   <= {n, 1'b0};
    end
  end

  mcp_point u_point (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_vld_q),
    .tag_i    (in_tag_q),
    .mat_i    (in_mat_q),
    .vneg_i   (in_vneg_q),
    .vmag_i   (in_vmag_q),
    .span_i   (in_span_q),
    .n2_i     (in_n2_q),
    .centre_i (centre_real_q),
    .valid_o  (pt_vld),
    .tag_o    (pt_tag),
    .mat_o    (pt_mat),
    .point_o  (pt_point)
  );

  mcp_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pt_vld),
    .tag_i   (pt_tag),
    .mat_i   (pt_mat),
    .point_i (pt_point),
    .valid_o (fr_vld),
    .tag_o   (fr_tag),
    .frac_o  (fr_frac)
  );

  mcp_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fr_vld),
    .tag_i     (fr_tag),
    .frac_i    (fr_frac),
    .columns_i (columns_q),
    .rows_i    (rows_q),
    .span_i    (span_y_q),
    .centre_i  (centre_imag_q),
    .valid_o   (out_vld),
    .col_o     (out_col),
    .row_o     (out_row),
    .hit_o     (out_hit)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = OUT_DATA_W'({out_row, out_col});
  assign m_axis_tuser  = out_hit;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("missed sample carries nonzero pixel");

  a_cfg_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i > CFG_SPAN_Y) |=>
      $stable(columns_q) && $stable(rows_q) && $stable(span_x_q) && $stable(span_y_q)
      && $stable(centre_real_q) && $stable(centre_imag_q))
    else $error("write to unused register index changed configuration");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(in_tag_q) && $stable(in_vld_q))
    else $error("input stage moved during stall");

endmodule

// ===== tb/tb_mobius_curve_pixel_plotter_top.sv =====
// Testbench of the Mobius curve pixel plotter: directed and random samples checked against a predictor.
`timescale 1ns / 1ps
module tb_mobius_curve_pixel_plotter_top;
  import mcp_pkg::*;

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_INV = 1'b1;
  localparam int   DRAIN_CYCLES = 140;
  localparam int   STALL_LIMIT  = 3000;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             hit;
  } pixel_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mobius_curve_pixel_plotter_top uut (.*);

  logic [DIM_W-1:0]          view_cols, view_rows;
  logic signed [COORD_W-1:0] view_cre, view_cim;
  logic [SPAN_W-1:0]         view_spx, view_spy;

  pixel_t expected_pixels[$];
  int     errors;
  int     quiet_cycles;
  int     send_idle_pct, recv_idle_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic pixel_t plot_pixel(input logic inv, input logic [IDX_W-1:0] idx,
                                        input logic signed [31:0] ma, mb, mc, md);
    longint a, b, c, d, t, n, m, s, i, p, num, den, f, j;
    longint unsigned r, ud;
    pixel_t px;
    px = '0;
    a = ma; b = mb; c = mc; d = md; i = idx;
    if (view_cols == 0 || view_rows == 0 || view_cols > MAX_DIM || view_rows > MAX_DIM)
      return px;
    if (view_spx == 0 || view_spy == 0) return px;
    if (inv) begin
      t = a; a = d; d = t; b = -b; c = -c;
      n = view_rows; m = view_cols; s = view_spy;
    end else begin
      n = view_cols; m = view_rows; s = view_spx;
    end
    if (i >= n) return px;
    p = longint'(view_cre) + floor_div(s * (2 * i + 1 - n), 2 * n);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    num = a * p + (b <<< FRAC_BITS);
    den = c * p + (d <<< FRAC_BITS);
    if (den == 0) return px;
    if (den < 0) begin
      num = -num; den = -den;
    end
    t = num % den;
    if (t < 0) t += den;
    r = t; ud = den; f = 0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      r = r << 1;
      f = f << 1;
      if (r >= ud) begin
        r -= ud; f |= 1;
      end
    end
    j = floor_div(m * longint'(view_spy) + 2 * m * (f - longint'(view_cim)),
                  2 * longint'(view_spy));
    j = (m - 1) - j;
    if (j < 0 || j >= m) return px;
    px.col = inv ? j[IDX_W-1:0] : idx;
    px.row = inv ? idx : j[IDX_W-1:0];
    px.hit = 1'b1;
    return px;
  endfunction

  // predict at input transfer, compare at output transfer
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(plot_pixel(s_axis_tuser[0], s_axis_tdata[IDX_W-1:0],
          s_axis_tdata[IDX_W+:32], s_axis_tdata[IDX_W+32+:32],
          s_axis_tdata[IDX_W+64+:32], s_axis_tdata[IDX_W+96+:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.col = m_axis_tdata[IDX_W-1:0];
        got.row = m_axis_tdata[2*IDX_W-1:IDX_W];
        got.hit = m_axis_tuser[0];
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result col=%0d row=%0d hit=%0d",
                   $time, got.col, got.row, got.hit);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.col !== want.col) begin
            $display("%0t: pixel_col expected %0d actual %0d", $time, want.col, got.col);
            errors++;
          end
          if (got.row !== want.row) begin
            $display("%0t: pixel_row expected %0d actual %0d", $time, want.row, got.row);
            errors++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = value;
    case (idx)
      CFG_COLUMNS:     view_cols = value[DIM_W-1:0];
      CFG_ROWS:        view_rows = value[DIM_W-1:0];
      CFG_CENTRE_REAL: view_cre  = value;
      CFG_CENTRE_IMAG: view_cim  = value;
      CFG_SPAN_X:      view_spx  = value[SPAN_W-1:0];
      CFG_SPAN_Y:      view_spy  = value[SPAN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_sample(input logic inv, input logic [IDX_W-1:0] idx,
                             input logic [31:0] a, b, c, d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, d, c, b, a, idx};
    s_axis_tuser  = inv;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_entry;
    case ($urandom_range(9))
      6: return $urandom;
      7: return 32'h8000_0000;
      8: return 32'h7fff_ffff;
      9: return 32'h0;
      default: return 32'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic rand_view;
    logic [31:0] v;
    for (int r = 0; r < 2; r++) begin
      case ($urandom_range(3))
        0: v = 1;
        1: v = MAX_DIM;
        2: v = $urandom_range(64, 1);
        default: v = $urandom_range(MAX_DIM, 1);
      endcase
      write_reg(r == 0 ? CFG_COLUMNS : CFG_ROWS, v);
    end
    for (int r = 0; r < 2; r++) begin
      case ($urandom_range(4))
        0: v = $urandom;
        1: v = 32'h8000_0000;
        2: v = 32'h7fff_ffff;
        default: v = 32'($signed($urandom_range(262144)) - 131072);
      endcase
      write_reg(r == 0 ? CFG_CENTRE_REAL : CFG_CENTRE_IMAG, v);
    end
    for (int r = 0; r < 2; r++) begin
      case ($urandom_range(4))
        0: v = 1;
        1: v = 32'h7fff_ffff;
        2: v = $urandom_range(32'h7fff_ffff, 1);
        default: v = $urandom_range(262144, 1);
      endcase
      write_reg(r == 0 ? CFG_SPAN_X : CFG_SPAN_Y, v);
    end
  endtask

  task automatic test_directed;
    send_sample(ACT_FWD, 0, 1, 0, 0, 1);
    send_sample(ACT_INV, 0, 1, 0, 0, 1);
    send_sample(ACT_FWD, 511, 2, 1, 1, 3);
    send_sample(ACT_INV, 511, 2, 1, 1, 3);
    send_sample(ACT_FWD, 100, 0, 0, 0, 0);
    send_sample(ACT_INV, 7, 1, 1, 1, 1);
    send_sample(ACT_FWD, 512, 1, 0, 0, 1);
    send_sample(ACT_INV, 12'hfff, 1, 0, 0, 1);
    send_sample(ACT_FWD, 3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(ACT_INV, 3, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_sample(ACT_FWD, 200, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    drain;
    write_reg(CFG_COLUMNS, 0);
    send_sample(ACT_FWD, 0, 1, 0, 0, 1);
    drain;
    write_reg(CFG_COLUMNS, 8191);
    send_sample(ACT_INV, 0, 1, 0, 0, 1);
    drain;
    write_reg(CFG_COLUMNS, MAX_DIM);
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_SPAN_X, 0);
    send_sample(ACT_FWD, 0, 1, 0, 0, 1);
    drain;
    write_reg(CFG_SPAN_X, 65536);
    write_reg(CFG_SPAN_Y, 0);
    send_sample(ACT_INV, 0, 1, 0, 0, 1);
    drain;
    write_reg(CFG_SPAN_Y, 65536);
    send_sample(ACT_FWD, 4095, 1, 0, 0, 1);
    send_sample(ACT_INV, 0, 3, 1, 0, 1);
    drain;
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic inv;
    int   lim;
    for (int ph = 0; ph < phases; ph++) begin
      rand_view();
      for (int k = 0; k < per_phase; k++) begin
        inv = $urandom_range(1);
        lim = inv ? int'(view_rows) : int'(view_cols);
        if (lim < 1 || lim > MAX_DIM || $urandom_range(19) == 0) lim = MAX_DIM;
        send_sample(inv, 12'($urandom_range(lim - 1)),
                    rand_entry(), rand_entry(), rand_entry(), rand_entry());
      end
      drain;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    errors = 0; quiet_cycles = 0;
    send_idle_pct = 15; recv_idle_pct = 61;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_COLUMNS; cfg_data_i = '0;
    view_cols = DIM_RST; view_rows = DIM_RST;
    view_cre = CENTRE_RST; view_cim = CENTRE_RST;
    view_spx = SPAN_RST; view_spy = SPAN_RST;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(4, 150);
    send_idle_pct = 61; recv_idle_pct = 15;
    test_random(4, 150);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(4, 150);

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_pixels.size() != 0)
        $display("%0t: %0d results missing", $time, expected_pixels.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
